// ===== sv/flood_relay_duplicate_filter_macros.svh =====
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter_macros.svh
// Assertion macros used by the duplicate filter checker.
// ----------------------------------------------------------------------------
`ifndef FLOOD_RELAY_DUPLICATE_FILTER_MACROS_SVH
`define FLOOD_RELAY_DUPLICATE_FILTER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdf assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define FDF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdf assertion failed");

`endif

// ===== sv/fdf_pkg.sv =====
// ----------------------------------------------------------------------------
// fdf_pkg
// Types, codes and constants of the flood relay duplicate filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 32;

    localparam int ID_W      = 8;
    localparam int STAMP_W   = 16;
    localparam int TIMEOUT_W = 15;
    localparam int VERDICT_W = 3;
    localparam int ENTRIES_W = 6;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_OWN_NODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OWN_GROUP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 15'd60;

    localparam logic [VERDICT_W-1:0] VERDICT_DUP        = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_OWN        = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_RELAY      = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_SINGLE     = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_REASSEMBLE = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_TICK       = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]      own_node;
        logic [ID_W-1:0]      own_group;
        logic [TIMEOUT_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    grp;
        logic [ID_W-1:0]    msg;
        logic [ID_W-1:0]    seq;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// ===== sv/flood_relay_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter
// Duplicate suppression and relay decision for a flooding mesh node.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   i_operation selects a time tick or a received packet header.
//   Result: o_valid pulses for one cycle with verdict, table_full and the
//   entry count; the receiver cannot stall, so every pulse must be taken.
//   A tick is handled in the idle state and busy stays low, so ticks can
//   follow each other every cycle.
//   A header reads the history memory one entry per cycle: a duplicate
//   scan of the N stored entries, ending early on a hit; then, unless the
//   source is this node, the header is appended if there is room and a
//   compaction pass over the table drops expired entries. Both passes
//   are serial, set by the single read port of the history memory.
//   Configuration goes through the APB port only while idle; the user
//   ensures this, the block does not. Reset empties the table, zeroes the
//   tick counter and loads register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter import fdf_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [ID_W-1:0]       i_source_id,
    input  logic [ID_W-1:0]       i_group_id,
    input  logic [ID_W-1:0]       i_message_id,
    input  logic [ID_W-1:0]       i_sequence_number,
    input  logic                  i_last_segment,
    output logic                  o_valid,
    output logic [VERDICT_W-1:0]  o_verdict,
    output logic                  o_table_full,
    output logic [ENTRIES_W-1:0]  o_entries_in_use
);

    t_cfg w_cfg;
    logic w_busy;

    fdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fdf_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_start           (start && !w_busy),
        .i_operation       (i_operation),
        .i_source_id       (i_source_id),
        .i_group_id        (i_group_id),
        .i_message_id      (i_message_id),
        .i_sequence_number (i_sequence_number),
        .i_last_segment    (i_last_segment),
        .o_busy            (w_busy),
        .o_valid           (o_valid),
        .o_verdict         (o_verdict),
        .o_table_full      (o_table_full),
        .o_entries_in_use  (o_entries_in_use)
    );

    assign busy = w_busy;

endmodule

// ===== sv/fdf_regs.sv =====
// ----------------------------------------------------------------------------
// fdf_regs
// APB register file: own node id, own group id, history timeout.
// ----------------------------------------------------------------------------
module fdf_regs import fdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_node  <= '0;
            r_cfg.own_group <= '0;
            r_cfg.timeout   <= TIMEOUT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_OWN_NODE:  r_cfg.own_node  <= pwdata[ID_W-1:0];
                REG_OWN_GROUP: r_cfg.own_group <= pwdata[ID_W-1:0];
                REG_TIMEOUT:   r_cfg.timeout   <= pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_OWN_NODE:  prdata = APB_DATA_W'(r_cfg.own_node);
            REG_OWN_GROUP: prdata = APB_DATA_W'(r_cfg.own_group);
            REG_TIMEOUT:   prdata = APB_DATA_W'(r_cfg.timeout);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/fdf_core.sv =====
// ----------------------------------------------------------------------------
// fdf_core
// History table memory and the scan / append / compact sequencer.
// ----------------------------------------------------------------------------
module fdf_core import fdf_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_start,
    input  logic                 i_operation,
    input  logic [ID_W-1:0]      i_source_id,
    input  logic [ID_W-1:0]      i_group_id,
    input  logic [ID_W-1:0]      i_message_id,
    input  logic [ID_W-1:0]      i_sequence_number,
    input  logic                 i_last_segment,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [VERDICT_W-1:0] o_verdict,
    output logic                 o_table_full,
    output logic [ENTRIES_W-1:0] o_entries_in_use
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [STAMP_W-1:0]   r_now, n_now;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_wr, n_wr;
    logic                 r_pend, n_pend;
    logic                 r_valid, n_valid;
    logic [VERDICT_W-1:0] r_verdict, n_verdict;
    logic                 r_full, n_full;
    logic [ENTRIES_W-1:0] r_out_count, n_out_count;

    logic [ID_W-1:0] r_src, r_grp, r_msg, r_seq;
    logic            r_last;

    t_entry r_mem [HISTORY_DEPTH];
    t_entry r_rd_data;

    logic               w_load;
    logic               w_re;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_entry             w_wdata;
    logic               w_issue;
    logic               w_hit;
    logic               w_drained;
    logic               w_keep;
    logic [STAMP_W-1:0] w_age;
    logic [VERDICT_W-1:0] w_pass_verdict;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign w_issue   = (r_idx < r_count);
    assign w_re      = w_issue && (r_state != S_IDLE);
    assign w_drained = !r_pend && !w_issue;
    assign w_hit     = r_pend && (r_rd_data.src == r_src) && (r_rd_data.grp == r_grp)
                       && (r_rd_data.msg == r_msg) && (r_rd_data.seq == r_seq);
    assign w_age     = r_now - r_rd_data.stamp;
    assign w_keep    = (w_age < {1'b0, i_cfg.timeout});

    always_comb begin
        if (r_grp != i_cfg.own_group) begin
            w_pass_verdict = VERDICT_RELAY;
        end else if (r_last && (r_seq == '0)) begin
            w_pass_verdict = VERDICT_SINGLE;
        end else begin
            w_pass_verdict = VERDICT_REASSEMBLE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_now       = r_now;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_pend      = 1'b0;
        n_valid     = 1'b0;
        n_verdict   = r_verdict;
        n_full      = r_full;
        n_out_count = r_out_count;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_wr[AW-1:0];
        w_wdata     = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation) begin
                        n_now       = r_now + 16'd1;
                        n_valid     = 1'b1;
                        n_verdict   = VERDICT_TICK;
                        n_full      = 1'b0;
                        n_out_count = ENTRIES_W'(r_count);
                    end else begin
                        w_load  = 1'b1;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_hit) begin
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                    n_valid     = 1'b1;
                    n_verdict   = VERDICT_DUP;
                    n_full      = 1'b0;
                    n_out_count = ENTRIES_W'(r_count);
                end else if (w_drained) begin
                    if (r_src == i_cfg.own_node) begin
                        n_state     = S_IDLE;
                        n_valid     = 1'b1;
                        n_verdict   = VERDICT_OWN;
                        n_full      = 1'b0;
                        n_out_count = ENTRIES_W'(r_count);
                    end else begin
                        if (r_count < DEPTH_C) begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            w_wdata = '{src: r_src, grp: r_grp, msg: r_msg,
                                        seq: r_seq, stamp: r_now};
                            n_count = r_count + 1'b1;
                            n_full  = 1'b0;
                        end else begin
                            n_full = 1'b1;
                        end
                        n_idx   = '0;
                        n_wr    = '0;
                        n_state = S_COMPACT;
                    end
                end
            end
            S_COMPACT: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend && w_keep) begin
                    w_we    = 1'b1;
                    w_waddr = r_wr[AW-1:0];
                    w_wdata = r_rd_data;
                    n_wr    = r_wr + 1'b1;
                end
                if (w_drained) begin
                    n_count     = r_wr;
                    n_state     = S_IDLE;
                    n_valid     = 1'b1;
                    n_verdict   = w_pass_verdict;
                    n_out_count = ENTRIES_W'(r_wr);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_now   <= '0;
            r_idx   <= '0;
            r_wr    <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_now   <= n_now;
            r_idx   <= n_idx;
            r_wr    <= n_wr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict   <= n_verdict;
        r_full      <= n_full;
        r_out_count <= n_out_count;
        if (w_load) begin
            r_src  <= i_source_id;
            r_grp  <= i_group_id;
            r_msg  <= i_message_id;
            r_seq  <= i_sequence_number;
            r_last <= i_last_segment;
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_verdict        = r_verdict;
    assign o_table_full     = r_full;
    assign o_entries_in_use = r_out_count;

endmodule

// ===== sv/fdf_checker.sv =====
// ----------------------------------------------------------------------------
// fdf_checker
// Port-level checks of the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "flood_relay_duplicate_filter_macros.svh"

module fdf_checker import fdf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 i_operation,
    input logic                 o_valid,
    input logic [VERDICT_W-1:0] o_verdict,
    input logic                 o_table_full
);

    `FDF_ASSERT_NXT(a_tick_result, start && !busy && i_operation, o_valid && (o_verdict == VERDICT_TICK) && !o_table_full)
    `FDF_ASSERT_NXT(a_header_busy, start && !busy && !i_operation, busy && !o_valid)
    `FDF_ASSERT_IMP(a_busy_quiet, busy, !o_valid)
    `FDF_ASSERT_IMP(a_done_result, $fell(busy), o_valid && (o_verdict != VERDICT_TICK))
    `FDF_ASSERT_IMP(a_full_relays, o_valid && o_table_full, (o_verdict == VERDICT_RELAY) || (o_verdict == VERDICT_SINGLE) || (o_verdict == VERDICT_REASSEMBLE))

endmodule

bind flood_relay_duplicate_filter fdf_checker u_fdf_checker (.*);
